[rtl/tga_pkg.sv]
package tga_pkg;

    localparam int ADDR_W = 36;
    localparam int HDR_LEN = 18;

    localparam logic [1:0] K_SEGMENT = 2'd0;
    localparam logic [1:0] K_ACCEPT  = 2'd1;
    localparam logic [1:0] K_REJECT  = 2'd2;
    localparam logic [1:0] K_DONE    = 2'd3;

    localparam logic [2:0] PH_IDLE   = 3'd0;
    localparam logic [2:0] PH_HEADER = 3'd1;
    localparam logic [2:0] PH_SKIP   = 3'd2;
    localparam logic [2:0] PH_PACKET = 3'd3;
    localparam logic [2:0] PH_PIXEL  = 3'd4;

    localparam logic [0:0] REG_START_OFFSET = 1'd0;
    localparam logic [0:0] REG_ADD_PLANE    = 1'd1;

    localparam logic [7:0] TYPE_RAW = 8'd2;
    localparam logic [7:0] TYPE_RLE = 8'd10;
    localparam logic [7:0] BPP_24   = 8'd24;
    localparam logic [7:0] BPP_32   = 8'd32;

    typedef logic [ADDR_W-1:0] t_addr;

endpackage

[rtl/tga_mul.sv]
module tga_mul (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_start,
    input  logic [15:0] i_a,
    input  logic [15:0] i_b,
    output logic        o_done,
    output logic [31:0] o_product
);
    logic        r_busy;
    logic        r_done;
    logic [3:0]  r_cnt;
    logic [31:0] r_acc;
    logic [31:0] r_a;
    logic [15:0] r_b;

    // one multiplier bit per cycle
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_busy <= 1'b1;
                r_cnt  <= '0;
                r_acc  <= '0;
                r_a    <= {16'd0, i_a};
                r_b    <= i_b;
            end else if (r_busy) begin
                if (r_b[0]) begin
                    r_acc <= r_acc + r_a;
                end
                r_a   <= {r_a[30:0], 1'b0};
                r_b   <= {1'b0, r_b[15:1]};
                r_cnt <= r_cnt + 4'd1;
                if (r_cnt == 4'd15) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    assign o_done    = r_done;
    assign o_product = r_acc;
endmodule

[rtl/tga_rle_image_decoder_unit.sv]
// timing: header, id and packet bytes are taken in the idle state; the last header byte adds
// the ST_FIN state, a completed pixel adds an ST_SEG pass per row segment, image start adds
// ST_START and both multiplies, and each new row adds the shift-add row multiply
// throughput: one item per cycle while the sequencer is idle (no header end, skip end or pixel
// completion pending); the single iterative 16x16 multiplier sets the cost of every row start
// reset: synchronous active low; clears parser, sequencer, output valid and config registers
module tga_rle_image_decoder_unit (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_in_valid,
    output logic                  o_in_stall,
    input  logic [7:0]            i_data_byte,
    input  logic                  i_file_start,
    output logic                  o_out_valid,
    input  logic                  i_out_stall,
    output logic [1:0]            o_result_kind,
    output logic [tga_pkg::ADDR_W-1:0] o_byte_address,
    output logic [7:0]            o_red,
    output logic [7:0]            o_green,
    output logic [7:0]            o_blue,
    output logic [7:0]            o_alpha,
    output logic [7:0]            o_repeat_count,
    output logic [15:0]           o_image_width,
    output logic [15:0]           o_image_height,
    output logic                  o_last_result,
    input  logic                  i_cfg_we,
    input  logic [0:0]            i_cfg_index,
    input  logic [23:0]           i_cfg_data
);
    import tga_pkg::*;

    localparam logic [3:0] ST_IDLE     = 4'd0;
    localparam logic [3:0] ST_FIN      = 4'd1;
    localparam logic [3:0] ST_START    = 4'd2;
    localparam logic [3:0] ST_WH_GO    = 4'd3;
    localparam logic [3:0] ST_WH_WAIT  = 4'd4;
    localparam logic [3:0] ST_ROW_GO   = 4'd5;
    localparam logic [3:0] ST_ROW_WAIT = 4'd6;
    localparam logic [3:0] ST_SEG      = 4'd7;
    localparam logic [3:0] ST_DONE     = 4'd8;

    logic [23:0] r_start_offset;
    logic        r_add_plane;

    logic [3:0]  r_state;
    logic [2:0]  r_phase;
    logic [4:0]  r_hdr_cnt;
    logic [7:0]  r_hdr [HDR_LEN];
    logic [7:0]  r_skip;
    logic [15:0] r_row_left;
    logic [15:0] r_col;
    logic [7:0]  r_pkt_left;
    logic        r_pkt_run;
    logic [1:0]  r_pb_pos;
    logic [7:0]  r_pix [3];
    logic [7:0]  r_alpha;
    logic [7:0]  r_cnt;
    logic [31:0] r_wh;
    t_addr       r_row_base;

    logic        r_ovalid;
    logic [1:0]  r_okind;
    t_addr       r_oaddr;
    logic [7:0]  r_ored, r_ogreen, r_oblue, r_oalpha, r_orep;
    logic [15:0] r_owidth, r_oheight;
    logic        r_olast;

    logic [15:0] w_width, w_height, w_real, w_room, w_n16, w_mul_a, w_mul_b;
    logic        w_rle, w_32, w_empty, w_hdr_ok, w_out_free, w_accept, w_wrap;
    logic        w_mul_start, w_mul_done, w_seg_last, w_load;
    logic [31:0] w_mul_p;
    logic [7:0]  w_n;
    t_addr       w_base;

    assign w_width  = {r_hdr[13], r_hdr[12]};
    assign w_height = {r_hdr[15], r_hdr[14]};
    assign w_rle    = (r_hdr[2] == TYPE_RLE);
    assign w_32     = (r_hdr[16] == BPP_32);
    assign w_empty  = (w_width == 16'd0) || (w_height == 16'd0);
    assign w_hdr_ok = (r_hdr[1] == 8'd0)
                   && ((r_hdr[2] == TYPE_RAW) || (r_hdr[2] == TYPE_RLE))
                   && ((r_hdr[16] == BPP_24) || (r_hdr[16] == BPP_32))
                   && !(w_rle && (w_width < 16'd3));

    assign w_out_free = !r_ovalid || !i_out_stall;
    assign w_accept   = i_in_valid && (r_state == ST_IDLE);
    assign o_in_stall = (r_state != ST_IDLE);
    assign w_load     = w_out_free
                     && ((r_state == ST_FIN) || (r_state == ST_SEG) || (r_state == ST_DONE));

    // sequence row to stored row
    assign w_real = r_hdr[17][5] ? (w_height - r_row_left) : (r_row_left - 16'd1);

    assign w_mul_start = (r_state == ST_WH_GO) || (r_state == ST_ROW_GO);
    assign w_mul_a     = (r_state == ST_WH_GO) ? w_width : w_real;
    assign w_mul_b     = (r_state == ST_WH_GO) ? w_height : w_width;

    tga_mul u_mul (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_start   (w_mul_start),
        .i_a       (w_mul_a),
        .i_b       (w_mul_b),
        .o_done    (w_mul_done),
        .o_product (w_mul_p)
    );

    assign w_base = t_addr'(r_start_offset)
                  + (r_add_plane ? t_addr'(r_wh) : t_addr'(0))
                  + t_addr'({w_mul_p, 2'b00});

    // segment split at the row end
    assign w_room     = w_width - r_col;
    assign w_n16      = ({8'd0, r_cnt} < w_room) ? {8'd0, r_cnt} : w_room;
    assign w_n        = w_n16[7:0];
    assign w_wrap     = (w_n16 == w_room);
    assign w_seg_last = (r_cnt == w_n) && !(w_wrap && (r_row_left == 16'd1));

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_start_offset <= '0;
            r_add_plane    <= 1'b0;
            r_state        <= ST_IDLE;
            r_phase        <= PH_IDLE;
            r_hdr_cnt      <= '0;
            r_skip         <= '0;
            r_row_left     <= '0;
            r_col          <= '0;
            r_pkt_left     <= '0;
            r_pkt_run      <= 1'b0;
            r_pb_pos       <= '0;
            r_row_base     <= '0;
            r_cnt          <= '0;
            r_ovalid       <= 1'b0;
        end else begin
            if (i_cfg_we) begin
                if (i_cfg_index == REG_START_OFFSET) begin
                    r_start_offset <= i_cfg_data;
                end else if (i_cfg_index == REG_ADD_PLANE) begin
                    r_add_plane <= i_cfg_data[0];
                end
            end

            if (w_load) begin
                r_ovalid <= 1'b1;
            end else if (!i_out_stall) begin
                r_ovalid <= 1'b0;
            end

            case (r_state)
                ST_IDLE: begin
                    if (w_accept) begin
                        if (i_file_start) begin
                            r_hdr[0]   <= i_data_byte;
                            r_hdr_cnt  <= 5'd1;
                            r_phase    <= PH_HEADER;
                            r_skip     <= '0;
                            r_row_left <= '0;
                            r_col      <= '0;
                            r_pkt_left <= '0;
                            r_pkt_run  <= 1'b0;
                            r_pb_pos   <= '0;
                        end else begin
                            case (r_phase)
                                PH_HEADER: begin
                                    if (r_hdr_cnt < 5'(HDR_LEN)) begin
                                        r_hdr[r_hdr_cnt] <= i_data_byte;
                                    end
                                    r_hdr_cnt <= r_hdr_cnt + 5'd1;
                                    if (r_hdr_cnt == 5'(HDR_LEN - 1)) begin
                                        r_state <= ST_FIN;
                                    end
                                end
                                PH_SKIP: begin
                                    r_skip <= r_skip - 8'd1;
                                    if (r_skip == 8'd1) begin
                                        r_state <= ST_START;
                                    end
                                end
                                PH_PACKET: begin
                                    r_pkt_left <= {1'b0, i_data_byte[6:0]} + 8'd1;
                                    r_pkt_run  <= i_data_byte[7];
                                    r_pb_pos   <= '0;
                                    r_phase    <= PH_PIXEL;
                                end
                                PH_PIXEL: begin
                                    if (r_pb_pos != 2'd3) begin
                                        r_pix[r_pb_pos] <= i_data_byte;
                                        r_alpha  <= 8'hff;
                                    end else begin
                                        r_alpha <= i_data_byte;
                                    end
                                    if ((r_pb_pos == 2'd3) || (r_pb_pos == 2'd2 && !w_32)) begin
                                        r_pb_pos <= '0;
                                        r_state  <= ST_SEG;
                                        if (w_rle && r_pkt_run) begin
                                            r_cnt      <= r_pkt_left;
                                            r_pkt_left <= '0;
                                            r_phase    <= PH_PACKET;
                                        end else begin
                                            r_cnt <= 8'd1;
                                            if (r_pkt_left != 8'd0) begin
                                                r_pkt_left <= r_pkt_left - 8'd1;
                                            end
                                            if (w_rle && r_pkt_left <= 8'd1) begin
                                                r_phase <= PH_PACKET;
                                            end
                                        end
                                    end else begin
                                        r_pb_pos <= r_pb_pos + 2'd1;
                                    end
                                end
                                default: begin
                                    r_phase <= PH_IDLE;
                                end
                            endcase
                        end
                    end
                end
                ST_FIN: begin
                    if (w_out_free) begin
                        r_okind   <= w_hdr_ok ? K_ACCEPT : K_REJECT;
                        r_oaddr   <= '0;
                        r_ored    <= '0;
                        r_ogreen  <= '0;
                        r_oblue   <= '0;
                        r_oalpha  <= '0;
                        r_orep    <= '0;
                        r_owidth  <= w_width;
                        r_oheight <= w_height;
                        r_olast   <= !w_hdr_ok || (r_hdr[0] != 8'd0) || !w_empty;
                        r_pb_pos   <= '0;
                        r_pkt_left <= '0;
                        r_pkt_run  <= 1'b0;
                        if (!w_hdr_ok) begin
                            r_phase <= PH_IDLE;
                            r_state <= ST_IDLE;
                        end else if (r_hdr[0] != 8'd0) begin
                            r_skip  <= r_hdr[0];
                            r_phase <= PH_SKIP;
                            r_state <= ST_IDLE;
                        end else begin
                            r_state <= ST_START;
                        end
                    end
                end
                ST_START: begin
                    if (w_empty) begin
                        r_state <= ST_DONE;
                    end else begin
                        r_row_left <= w_height;
                        r_col      <= '0;
                        r_cnt      <= '0;
                        r_phase    <= w_rle ? PH_PACKET : PH_PIXEL;
                        r_state    <= ST_WH_GO;
                    end
                end
                ST_WH_GO: begin
                    r_state <= ST_WH_WAIT;
                end
                ST_WH_WAIT: begin
                    if (w_mul_done) begin
                        r_wh    <= w_mul_p;
                        r_state <= ST_ROW_GO;
                    end
                end
                ST_ROW_GO: begin
                    r_state <= ST_ROW_WAIT;
                end
                ST_ROW_WAIT: begin
                    if (w_mul_done) begin
                        r_row_base <= w_base;
                        r_state    <= (r_cnt != 8'd0) ? ST_SEG : ST_IDLE;
                    end
                end
                ST_SEG: begin
                    if (w_out_free) begin
                        r_okind   <= K_SEGMENT;
                        r_oaddr   <= r_row_base + t_addr'({r_col, 2'b00});
                        r_ored    <= r_pix[2];
                        r_ogreen  <= r_pix[1];
                        r_oblue   <= r_pix[0];
                        r_oalpha  <= r_alpha;
                        r_orep    <= w_n;
                        r_owidth  <= w_width;
                        r_oheight <= w_height;
                        r_olast   <= w_seg_last;
                        r_cnt     <= r_cnt - w_n;
                        if (w_wrap) begin
                            r_col      <= '0;
                            r_row_left <= r_row_left - 16'd1;
                            if (r_row_left == 16'd1) begin
                                r_state <= ST_DONE;
                            end else begin
                                r_state <= ST_ROW_GO;
                            end
                        end else begin
                            r_col   <= r_col + w_n16;
                            r_state <= ST_IDLE;
                        end
                    end
                end
                ST_DONE: begin
                    if (w_out_free) begin
                        r_okind   <= K_DONE;
                        r_oaddr   <= '0;
                        r_ored    <= '0;
                        r_ogreen  <= '0;
                        r_oblue   <= '0;
                        r_oalpha  <= '0;
                        r_orep    <= '0;
                        r_owidth  <= w_width;
                        r_oheight <= w_height;
                        r_olast   <= 1'b1;
                        r_phase   <= PH_IDLE;
                        r_state   <= ST_IDLE;
                    end
                end
                default: begin
                    r_state <= ST_IDLE;
                end
            endcase
        end
    end

    assign o_out_valid    = r_ovalid;
    assign o_result_kind  = r_okind;
    assign o_byte_address = r_oaddr;
    assign o_red          = r_ored;
    assign o_green        = r_ogreen;
    assign o_blue         = r_oblue;
    assign o_alpha        = r_oalpha;
    assign o_repeat_count = r_orep;
    assign o_image_width  = r_owidth;
    assign o_image_height = r_oheight;
    assign o_last_result  = r_olast;
endmodule

[rtl/tga_checker.sv]
module tga_checker (
    input logic       i_clk,
    input logic       i_rst_n,
    input logic       o_out_valid,
    input logic       i_out_stall,
    input logic [1:0] o_result_kind,
    input logic [tga_pkg::ADDR_W-1:0] o_byte_address,
    input logic [7:0] o_red,
    input logic [7:0] o_repeat_count
);
    import tga_pkg::*;

    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && i_out_stall |=> o_out_valid)
        else $error("output item dropped while stalled");

    a_seg_rep: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && (o_result_kind == K_SEGMENT) |-> (o_repeat_count != 8'd0))
        else $error("empty segment");

    a_rep_len: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && (o_result_kind == K_SEGMENT) |-> (o_repeat_count <= 8'd128))
        else $error("segment longer than a packet");

    a_status_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && (o_result_kind != K_SEGMENT)
        |-> (o_repeat_count == 8'd0) && (o_byte_address == '0) && (o_red == 8'd0))
        else $error("status item carries pixel data");
endmodule

bind tga_rle_image_decoder_unit tga_checker u_tga_checker (
    .i_clk          (i_clk),
    .i_rst_n        (i_rst_n),
    .o_out_valid    (o_out_valid),
    .i_out_stall    (i_out_stall),
    .o_result_kind  (o_result_kind),
    .o_byte_address (o_byte_address),
    .o_red          (o_red),
    .o_repeat_count (o_repeat_count)
);

[bench/tb_tga_rle_image_decoder_unit.sv]
module tb_tga_rle_image_decoder_unit;
    import tga_pkg::*;

    typedef struct packed {
        logic [1:0]  kind;
        logic [35:0] addr;
        logic [7:0]  red;
        logic [7:0]  green;
        logic [7:0]  blue;
        logic [7:0]  alpha;
        logic [7:0]  rep;
        logic [15:0] width;
        logic [15:0] height;
        logic        last;
    } t_pixel_result;

    typedef struct packed {
        logic [7:0] data;
        logic       start;
    } t_file_byte;

    logic        i_clk = 1'b0;
    logic        i_rst_n = 1'b0;
    logic        i_in_valid = 1'b0;
    logic        o_in_stall;
    logic [7:0]  i_data_byte = 8'd0;
    logic        i_file_start = 1'b0;
    logic        o_out_valid;
    logic        i_out_stall = 1'b0;
    logic [1:0]  o_result_kind;
    logic [ADDR_W-1:0] o_byte_address;
    logic [7:0]  o_red, o_green, o_blue, o_alpha, o_repeat_count;
    logic [15:0] o_image_width, o_image_height;
    logic        o_last_result;
    logic        i_cfg_we = 1'b0;
    logic [0:0]  i_cfg_index = REG_START_OFFSET;
    logic [23:0] i_cfg_data = 24'd0;

    tga_rle_image_decoder_unit dut (.*);

    always begin
        #6 i_clk = 1'b1;
        #6 i_clk = 1'b0;
    end

    // decoder shadow state
    logic [23:0] cfg_start;
    logic        cfg_plane;
    logic [2:0]  phase;
    int          hdr_count;
    logic [7:0]  hdr [HDR_LEN];
    logic [7:0]  skip_n;
    logic [15:0] rows_left;
    logic [15:0] col;
    logic [7:0]  pkt_left;
    logic        pkt_run;
    logic [1:0]  pix_pos;
    logic [7:0]  pix [3];
    logic [63:0] row_base;

    t_pixel_result step_q[$];
    t_pixel_result expected_q[$];
    t_file_byte    file_q[$];

    bit failed = 1'b0;
    int results_seen = 0;

    function automatic logic [31:0] img_w();
        return {16'd0, hdr[13], hdr[12]};
    endfunction

    function automatic logic [31:0] img_h();
        return {16'd0, hdr[15], hdr[14]};
    endfunction

    function automatic bit is_rle();
        return hdr[2] == TYPE_RLE;
    endfunction

    function automatic void add_result(logic [1:0] kind, logic [63:0] addr,
                                       logic [7:0] r, logic [7:0] g, logic [7:0] b,
                                       logic [7:0] a, logic [7:0] rep);
        t_pixel_result res;
        if (step_q.size() >= 64)
            return;
        res.kind = kind;
        res.addr = addr[35:0];
        res.red = r;
        res.green = g;
        res.blue = b;
        res.alpha = a;
        res.rep = rep;
        res.width = img_w();
        res.height = img_h();
        res.last = 1'b0;
        step_q.push_back(res);
    endfunction

    function automatic void load_row_base();
        logic [63:0] w, h, r, real_row, base;
        w = img_w();
        h = img_h();
        r = h - rows_left;
        real_row = hdr[17][5] ? r : (h - 1 - r);
        base = cfg_start;
        if (cfg_plane)
            base += w * h;
        row_base = (base + real_row * w * 4) & ((64'd1 << ADDR_W) - 1);
    endfunction

    function automatic void begin_pixels();
        if (img_w() == 0 || img_h() == 0) begin
            add_result(K_DONE, 0, 0, 0, 0, 0, 0);
            phase = PH_IDLE;
            return;
        end
        rows_left = img_h();
        col = 0;
        load_row_base();
        phase = is_rle() ? PH_PACKET : PH_PIXEL;
    endfunction

    function automatic void write_pixels(logic [31:0] count, logic [7:0] r, logic [7:0] g,
                                         logic [7:0] b, logic [7:0] a);
        logic [31:0] room, n;
        while (count > 0 && phase != PH_IDLE) begin
            room = img_w() - col;
            n = (count < room) ? count : room;
            add_result(K_SEGMENT, (row_base + col * 4) & ((64'd1 << ADDR_W) - 1),
                       r, g, b, a, n[7:0]);
            col = col + n[15:0];
            count -= n;
            if (col >= img_w()) begin
                col = 0;
                rows_left--;
                if (rows_left == 0) begin
                    add_result(K_DONE, 0, 0, 0, 0, 0, 0);
                    phase = PH_IDLE;
                end else begin
                    load_row_base();
                end
            end
        end
    endfunction

    function automatic void check_header();
        bit ok;
        ok = hdr[1] == 0 && (hdr[2] == TYPE_RAW || hdr[2] == TYPE_RLE)
             && (hdr[16] == BPP_24 || hdr[16] == BPP_32);
        if (hdr[2] == TYPE_RLE && img_w() < 3)
            ok = 0;
        if (!ok) begin
            add_result(K_REJECT, 0, 0, 0, 0, 0, 0);
            phase = PH_IDLE;
            return;
        end
        add_result(K_ACCEPT, 0, 0, 0, 0, 0, 0);
        pix_pos = 0;
        pkt_left = 0;
        pkt_run = 0;
        if (hdr[0] != 0) begin
            skip_n = hdr[0];
            phase = PH_SKIP;
        end else begin
            begin_pixels();
        end
    endfunction

    function automatic void take_pixel_byte(logic [7:0] b);
        logic [7:0] a;
        if (pix_pos < 3) begin
            pix[pix_pos] = b;
            pix_pos++;
            if (pix_pos < 3 || hdr[16] == BPP_32)
                return;
            a = 8'hff;
        end else begin
            a = b;
        end
        pix_pos = 0;
        if (is_rle() && pkt_run) begin
            write_pixels(pkt_left, pix[2], pix[1], pix[0], a);
            pkt_left = 0;
        end else begin
            write_pixels(1, pix[2], pix[1], pix[0], a);
            if (pkt_left > 0)
                pkt_left--;
        end
        if (phase == PH_PIXEL && is_rle() && pkt_left == 0)
            phase = PH_PACKET;
    endfunction

    function automatic void decode_byte(t_file_byte fb);
        step_q.delete();
        if (fb.start) begin
            phase = PH_HEADER;
            hdr_count = 0;
            skip_n = 0;
            rows_left = 0;
            col = 0;
            pkt_left = 0;
            pkt_run = 0;
            pix_pos = 0;
        end
        case (phase)
            PH_HEADER: begin
                if (hdr_count < HDR_LEN)
                    hdr[hdr_count] = fb.data;
                hdr_count++;
                if (hdr_count >= HDR_LEN)
                    check_header();
            end
            PH_SKIP: begin
                skip_n--;
                if (skip_n == 0)
                    begin_pixels();
            end
            PH_PACKET: begin
                pkt_left = (fb.data & 8'h7f) + 1;
                pkt_run = fb.data[7];
                pix_pos = 0;
                phase = PH_PIXEL;
            end
            PH_PIXEL: take_pixel_byte(fb.data);
            default: phase = PH_IDLE;
        endcase
        if (step_q.size() > 0)
            step_q[step_q.size() - 1].last = 1'b1;
        foreach (step_q[i])
            expected_q.push_back(step_q[i]);
    endfunction

    // sender: bursts and gaps
    int burst_left = 0;
    int gap_left = 0;
    int accepted_in = 0;

    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            i_in_valid <= 1'b0;
        end else begin
            if (i_in_valid && !o_in_stall) begin
                decode_byte({i_data_byte, i_file_start});
                accepted_in++;
            end
            if (!(i_in_valid && o_in_stall)) begin
                if (gap_left > 0) begin
                    gap_left--;
                    i_in_valid <= 1'b0;
                end else if (file_q.size() > 0) begin
                    {i_data_byte, i_file_start} <= file_q.pop_front();
                    i_in_valid <= 1'b1;
                    if (burst_left > 0) begin
                        burst_left--;
                    end else begin
                        burst_left = $urandom_range(0, 40);
                        gap_left = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
                    end
                end else begin
                    i_in_valid <= 1'b0;
                end
            end
        end
    end

    // receiver: stall pattern plus one long hold
    int stall_mode = 0;
    int mode_left = 0;
    int hold_left = 0;
    bit hold_done = 1'b0;

    task automatic check_field(string name, logic [63:0] exp_v, logic [63:0] act_v);
        if (exp_v !== act_v) begin
            $display("%0t mismatch %s: expected %0h actual %0h", $time, name, exp_v, act_v);
            failed = 1'b1;
        end
    endtask

    always @(posedge i_clk) begin
        t_pixel_result e;
        if (!i_rst_n) begin
            i_out_stall <= 1'b0;
        end else begin
            if (o_out_valid && !i_out_stall) begin
                results_seen++;
                if (expected_q.size() == 0) begin
                    $display("%0t unexpected result: expected none actual kind %0d",
                             $time, o_result_kind);
                    failed = 1'b1;
                end else begin
                    e = expected_q.pop_front();
                    check_field("result_kind", e.kind, o_result_kind);
                    check_field("byte_address", e.addr, o_byte_address);
                    check_field("red", e.red, o_red);
                    check_field("green", e.green, o_green);
                    check_field("blue", e.blue, o_blue);
                    check_field("alpha", e.alpha, o_alpha);
                    check_field("repeat_count", e.rep, o_repeat_count);
                    check_field("image_width", e.width, o_image_width);
                    check_field("image_height", e.height, o_image_height);
                    check_field("last_result", e.last, o_last_result);
                end
            end
            if (!hold_done && results_seen >= 60) begin
                hold_done = 1'b1;
                hold_left = 400;
            end
            if (mode_left == 0) begin
                stall_mode = $urandom_range(0, 3);
                mode_left = $urandom_range(10, 80);
            end else begin
                mode_left--;
            end
            if (hold_left > 0) begin
                hold_left--;
                i_out_stall <= 1'b1;
            end else begin
                case (stall_mode)
                    0: i_out_stall <= 1'b0;
                    1: i_out_stall <= $urandom_range(0, 1);
                    2: i_out_stall <= ($urandom_range(0, 3) == 0);
                    default: i_out_stall <= ($urandom_range(0, 3) != 0);
                endcase
            end
        end
    end

    // watchdog on stalled progress
    int idle_cycles = 0;
    always @(posedge i_clk) begin
        if ((i_in_valid && !o_in_stall) || (o_out_valid && !i_out_stall)
            || (file_q.size() == 0 && expected_q.size() == 0 && !i_in_valid)) begin
            idle_cycles <= 0;
        end else if (idle_cycles >= 5000) begin
            $display("TEST FAILED");
            $finish;
        end else begin
            idle_cycles <= idle_cycles + 1;
        end
    end

    task automatic write_reg(logic [0:0] idx, logic [23:0] val);
        @(posedge i_clk);
        i_cfg_we <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data <= val;
        if (idx == REG_START_OFFSET)
            cfg_start = val;
        else
            cfg_plane = val[0];
        @(posedge i_clk);
        i_cfg_we <= 1'b0;
    endtask

    task automatic drain();
        wait (file_q.size() == 0 && !i_in_valid && expected_q.size() == 0);
        repeat (80) @(posedge i_clk);
    endtask

    task automatic push_byte(logic [7:0] b, logic s);
        file_q.push_back({b, s});
    endtask

    // one targa file; max_pix > 0 cuts the pixel stream short
    task automatic build_file(logic [7:0] idlen, logic [7:0] cmap, logic [7:0] typ,
                              logic [7:0] bpp, logic [15:0] w, logic [15:0] h,
                              logic attr5, int max_pix, bit overlong);
        int total, left, cnt, nb, lim;
        bit run;
        push_byte(idlen, 1'b1);
        push_byte(cmap, 1'b0);
        push_byte(typ, 1'b0);
        for (int i = 3; i < 12; i++)
            push_byte($urandom_range(0, 255), 1'b0);
        push_byte(w[7:0], 1'b0);
        push_byte(w[15:8], 1'b0);
        push_byte(h[7:0], 1'b0);
        push_byte(h[15:8], 1'b0);
        push_byte(bpp, 1'b0);
        push_byte({2'($urandom_range(0, 3)), attr5, 5'($urandom_range(0, 31))}, 1'b0);
        for (int i = 0; i < idlen; i++)
            push_byte($urandom_range(0, 255), 1'b0);
        total = w * h;
        if (max_pix > 0 && max_pix < total)
            total = max_pix;
        nb = (bpp == BPP_32) ? 4 : 3;
        left = total;
        while (left > 0) begin
            if (typ == TYPE_RLE) begin
                lim = left + (overlong ? 6 : 0);
                if (lim > 128)
                    lim = 128;
                cnt = ($urandom_range(0, 3) == 0) ? $urandom_range(1, lim)
                                                  : $urandom_range(1, (lim < 4) ? lim : 4);
                run = $urandom_range(0, 1);
                push_byte({run, 7'(cnt - 1)}, 1'b0);
                for (int p = 0; p < (run ? 1 : cnt); p++)
                    for (int k = 0; k < nb; k++)
                        push_byte($urandom_range(0, 255), 1'b0);
            end else begin
                cnt = 1;
                for (int k = 0; k < nb; k++)
                    push_byte($urandom_range(0, 255), 1'b0);
            end
            left -= cnt;
        end
    endtask

    initial begin
        int pick;
        logic [7:0] typ, bpp;
        cfg_start = 0;
        cfg_plane = 0;
        phase = PH_IDLE;
        hdr_count = 0;
        repeat (3) @(posedge i_clk);
        i_rst_n <= 1'b1;

        write_reg(REG_START_OFFSET, 24'd0);
        write_reg(REG_ADD_PLANE, 24'd0);

        // directed: stray bytes, rejects, empty images, small raw and rle, cut-short files
        push_byte(8'hff, 1'b0);
        push_byte(8'h00, 1'b0);
        build_file(0, 1, TYPE_RAW, BPP_24, 4, 2, 0, 0, 0);
        build_file(0, 0, 8'd3, BPP_24, 4, 2, 0, 0, 0);
        build_file(0, 0, TYPE_RAW, 8'd16, 4, 2, 0, 0, 0);
        build_file(0, 0, TYPE_RLE, BPP_32, 2, 2, 0, 0, 0);
        build_file(0, 0, TYPE_RAW, BPP_24, 0, 5, 0, 0, 0);
        build_file(2, 0, TYPE_RLE, BPP_32, 16'hffff, 0, 1, 0, 0);
        build_file(1, 0, TYPE_RAW, BPP_24, 3, 2, 0, 0, 0);
        build_file(0, 0, TYPE_RLE, BPP_32, 3, 3, 1, 0, 1);
        push_byte(8'h80, 1'b0);
        push_byte(8'h7f, 1'b0);
        build_file(0, 0, TYPE_RAW, BPP_32, 16'hffff, 16'hffff, 0, 2, 0);
        build_file(3, 0, TYPE_RLE, BPP_24, 5, 2, 0, 3, 0);
        drain();

        write_reg(REG_START_OFFSET, 24'hffffff);
        write_reg(REG_ADD_PLANE, 24'd1);

        for (int cfg_phase = 0; cfg_phase < 4; cfg_phase++) begin
            while (accepted_in < 100 + cfg_phase * 60 || file_q.size() > 0) begin
                if (file_q.size() > 0) begin
                    @(posedge i_clk);
                end else begin
                    pick = $urandom_range(0, 19);
                    typ = ($urandom_range(0, 1) == 0) ? TYPE_RAW : TYPE_RLE;
                    bpp = ($urandom_range(0, 1) == 0) ? BPP_24 : BPP_32;
                    if (pick == 0) begin
                        build_file($urandom_range(0, 255), $urandom_range(0, 1),
                                   $urandom_range(0, 255), $urandom_range(0, 255),
                                   $urandom_range(0, 65535), $urandom_range(0, 65535),
                                   $urandom_range(0, 1), 3, $urandom_range(0, 1));
                    end else if (pick == 1) begin
                        repeat ($urandom_range(1, 4))
                            push_byte($urandom_range(0, 255), 1'b0);
                    end else begin
                        build_file(($urandom_range(0, 3) == 0) ? $urandom_range(1, 4) : 0,
                                   0, typ, bpp, $urandom_range(3, 9),
                                   $urandom_range(1, 3), $urandom_range(0, 1),
                                   (pick == 2) ? $urandom_range(1, 5) : 0,
                                   $urandom_range(0, 1));
                    end
                end
            end
            drain();
            write_reg(REG_START_OFFSET, 24'($urandom_range(0, 24'hffffff)));
            write_reg(REG_ADD_PLANE, {23'd0, cfg_phase[0]});
        end

        drain();
        if (!failed && expected_q.size() == 0) begin
            $display("TEST PASSED");
        end else begin
            $display("TEST FAILED");
        end
        $finish;
    end

endmodule
